[rtl/core/prd_pkg.sv]
package prd_pkg;

  // Adapter ports that produce results.
  localparam int NUM_PORTS     = 4;
  localparam int REPORT_LEN    = 37;
  localparam int BLOCK_LEN     = 9;
  localparam int REPORT_BLOCKS = (REPORT_LEN - 1) / BLOCK_LEN;

  localparam int PORT_W    = $clog2(REPORT_BLOCKS);
  localparam int OFF_W     = $clog2(BLOCK_LEN);
  localparam int BLK_IDX_W = $clog2(BLOCK_LEN - 1);

  localparam logic [OFF_W-1:0] LAST_OFF     = OFF_W'(BLOCK_LEN - 1);
  localparam logic [PORT_W-1:0] LAST_BLOCK  = PORT_W'(REPORT_BLOCKS - 1);
  localparam logic [PORT_W-1:0] LAST_PORT   = PORT_W'(NUM_PORTS - 1);

  localparam logic [7:0] HEADER_BYTE = 8'h21;
  localparam logic [7:0] STATUS_MASK = 8'h30;

  typedef enum logic {
    MODE_BYTE  = 1'b0,
    MODE_RECAL = 1'b1
  } mode_t;

  // First eight bytes of a port block: status, buttons1, buttons2, main x,
  // main y, cstick x, cstick y, left trigger.
  typedef logic [BLOCK_LEN-2:0][7:0] blk_t;

  typedef struct packed {
    logic [7:0] main_x;
    logic [7:0] main_y;
    logic [7:0] cstick_x;
    logic [7:0] cstick_y;
    logic [7:0] left_trig;
    logic [7:0] right_trig;
  } origin_t;

  typedef struct packed {
    logic [PORT_W-1:0] port_number;
    logic              connected;
    logic              origin_captured;
    logic [12:0]       buttons;
    logic signed [7:0] main_x;
    logic signed [7:0] main_y;
    logic signed [7:0] cstick_x;
    logic signed [7:0] cstick_y;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic              last_port;
  } result_t;

  function automatic logic [12:0] remap_buttons(input logic [7:0] b1, input logic [7:0] b2);
    logic [12:0] b;
    b        = '0;
    b[3:0]   = b1[7:4];
    b[11:8]  = b1[3:0];
    b[12]    = b2[0];
    b[6:4]   = b2[3:1];
    return b;
  endfunction

endpackage

[rtl/core/prd_port_calc.sv]
module prd_port_calc (
  input  prd_pkg::blk_t                    blk,
  input  logic [7:0]                       last_byte,
  input  logic [prd_pkg::PORT_W-1:0]       port,
  input  prd_pkg::origin_t                 stored_origin,
  input  logic                             origin_valid,
  output logic                             connected,
  output prd_pkg::origin_t                 cap_origin,
  output prd_pkg::result_t                 res
);
  import prd_pkg::*;

  function automatic logic [7:0] axis_offset(input logic [7:0] v, input logic [7:0] o);
    logic signed [8:0] a;
    logic [7:0]        r;
    a = $signed({1'b0, v}) - $signed({1'b0, o});
    if (a[8] != a[7]) begin
      r = a[8] ? 8'h80 : 8'h7f;
    end else begin
      r = a[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] trig_offset(input logic [7:0] v, input logic [7:0] o);
    return (v > o) ? (v - o) : 8'd0;
  endfunction

  origin_t org;

  assign connected = ((blk[0] & STATUS_MASK) != 8'd0);

  // A fresh origin is simply the current stick and trigger readings.
  assign cap_origin = '{main_x: blk[3], main_y: blk[4], cstick_x: blk[5],
                        cstick_y: blk[6], left_trig: blk[7], right_trig: last_byte};

  assign org = origin_valid ? stored_origin : cap_origin;

  always_comb begin
    res             = '0;
    res.port_number = port;
    res.last_port   = (port == LAST_PORT);
    if (connected) begin
      res.connected       = 1'b1;
      res.origin_captured = !origin_valid;
      res.buttons         = remap_buttons(blk[1], blk[2]);
      res.main_x          = axis_offset(blk[3], org.main_x);
      res.main_y          = axis_offset(blk[4], org.main_y);
      res.cstick_x        = axis_offset(blk[5], org.cstick_x);
      res.cstick_y        = axis_offset(blk[6], org.cstick_y);
      res.left_trigger    = trig_offset(blk[7], org.left_trig);
      res.right_trigger   = trig_offset(last_byte, org.right_trig);
    end
  end

endmodule

[rtl/core/pad_report_decoder.sv]
// Controller adapter report decoder. Report bytes enter one item per clock
// while in_stall is low; a header item (start_of_report) opens a 37-byte
// report that is decoded only if its header is 0x21, and the last byte of
// each 9-byte port block yields one result item carrying the remapped
// buttons, stick offsets from the stored neutral point (saturated to
// -128..127) and trigger offsets floored at zero. A recalibrate item drops
// one port's neutral point, or all of them for a port number of four or
// more, and yields no result. All decoding sits between the accepted item
// and a single output register, so with out_stall low an item is taken
// every cycle and its result appears on the next. in_stall is high only
// while that output register holds a result that the far side is stalling.
// Writing adapter_disabled as 1 keeps byte tracking running but suppresses
// results and leaves the neutral points alone; write it only while no item
// is in flight. No clearing pass follows reset.
module pad_report_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input item channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_start_of_report,
  input  logic [2:0]                   in_recal_port,
  // Result item channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_port_number,
  output logic                         out_connected,
  output logic                         out_origin_captured,
  output logic [12:0]                  out_buttons,
  output logic signed [7:0]            out_main_x,
  output logic signed [7:0]            out_main_y,
  output logic signed [7:0]            out_cstick_x,
  output logic signed [7:0]            out_cstick_y,
  output logic [7:0]                   out_left_trigger,
  output logic [7:0]                   out_right_trigger,
  output logic                         out_last_port,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import prd_pkg::*;

  // Report tracking: active_r is set between a header and the final byte.
  logic              active_r;
  logic              report_ok_r;
  logic [OFF_W-1:0]  off_r;
  logic [PORT_W-1:0] port_r;
  blk_t              blk_r;

  logic              adapter_disabled_r;
  logic [NUM_PORTS-1:0] origin_valid_r;
  origin_t           origin_r [NUM_PORTS];

  logic              out_valid_r;
  result_t           result_r;

  logic              in_fire;
  logic              is_recal;
  logic              is_header;
  logic              is_byte;
  logic              block_end;
  logic              emit;
  logic              port_conn;
  origin_t           cap_origin;
  result_t           calc_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;

  assign is_recal  = in_fire && (in_mode == MODE_RECAL);
  assign is_header = in_fire && (in_mode == MODE_BYTE) && in_start_of_report;
  assign is_byte   = in_fire && (in_mode == MODE_BYTE) && !in_start_of_report && active_r;
  assign block_end = is_byte && (off_r == LAST_OFF);

  // Results only for a good report, with the adapter enabled, on a real port.
  assign emit = block_end && report_ok_r && !adapter_disabled_r &&
                ({1'b0, port_r} < (PORT_W + 1)'(NUM_PORTS));

  prd_port_calc u_calc (
    .blk           (blk_r),
    .last_byte     (in_data_byte),
    .port          (port_r),
    .stored_origin (origin_r[port_r]),
    .origin_valid  (origin_valid_r[port_r]),
    .connected     (port_conn),
    .cap_origin    (cap_origin),
    .res           (calc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapter_disabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      adapter_disabled_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      report_ok_r <= 1'b0;
      off_r       <= '0;
      port_r      <= '0;
    end else if (is_header) begin
      active_r    <= 1'b1;
      report_ok_r <= (in_data_byte == HEADER_BYTE);
      off_r       <= '0;
      port_r      <= '0;
    end else if (is_byte) begin
      if (off_r == LAST_OFF) begin
        off_r <= '0;
        if (port_r == LAST_BLOCK) begin
          active_r <= 1'b0;
          port_r   <= '0;
        end else begin
          port_r <= port_r + 1'b1;
        end
      end else begin
        off_r <= off_r + 1'b1;
      end
    end
  end

  // The first eight block bytes are held; the ninth is used straight off the port.
  always_ff @(posedge clk) begin
    if (is_byte && (off_r != LAST_OFF)) begin
      blk_r[off_r[BLK_IDX_W-1:0]] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_valid_r <= '0;
    end else if (is_recal) begin
      if (in_recal_port >= 3'(NUM_PORTS)) begin
        origin_valid_r <= '0;
      end else begin
        origin_valid_r[in_recal_port[PORT_W-1:0]] <= 1'b0;
      end
    end else if (emit) begin
      origin_valid_r[port_r] <= port_conn;
    end
  end

  // Stored origins are read only while their valid bit is set.
  always_ff @(posedge clk) begin
    if (emit && port_conn && !origin_valid_r[port_r]) begin
      origin_r[port_r] <= cap_origin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_r <= calc_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_port_number     = result_r.port_number;
  assign out_connected       = result_r.connected;
  assign out_origin_captured = result_r.origin_captured;
  assign out_buttons         = result_r.buttons;
  assign out_main_x          = result_r.main_x;
  assign out_main_y          = result_r.main_y;
  assign out_cstick_x        = result_r.cstick_x;
  assign out_cstick_y        = result_r.cstick_y;
  assign out_left_trigger    = result_r.left_trigger;
  assign out_right_trigger   = result_r.right_trigger;
  assign out_last_port       = result_r.last_port;

  // Outside a report the block counters sit at zero.
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (off_r == '0) && (port_r == '0))
    else $error("block counters not cleared outside a report");

  // A header item always restarts tracking at the first block byte.
  a_header_restart: assert property (@(posedge clk) disable iff (!rst_n)
    is_header |=> active_r && (off_r == '0) && (port_r == '0))
    else $error("header did not restart report tracking");

  // Recalibrating all ports leaves no neutral point held.
  a_recal_all: assert property (@(posedge clk) disable iff (!rst_n)
    is_recal && (in_recal_port >= 3'(NUM_PORTS)) |=> (origin_valid_r == '0))
    else $error("global recalibrate left an origin valid");

  // A disconnected result carries nothing but its port information.
  a_disc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_connected |-> !out_origin_captured && (out_buttons == '0) &&
      (out_main_x == '0) && (out_main_y == '0) && (out_cstick_x == '0) &&
      (out_cstick_y == '0) && (out_left_trigger == '0) && (out_right_trigger == '0))
    else $error("disconnected result has nonzero fields");

endmodule
